// ===== rtl/core/lmd_pkg.sv =====
// shared constants, types and register codes for the label mode downsampler
package lmd_pkg;

	localparam int MAX_OUT_WIDTH = 64;
	localparam int NUM_LABELS = 16;

	localparam int LABEL_W = 4;
	localparam int CELL_COL_W = 6;
	localparam int COL_W = $clog2(MAX_OUT_WIDTH);
	localparam int OW_W = 7;
	localparam int DIM_W = 13;
	localparam int POS_W = 12;
	localparam int CNT_W = 16;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;

	// two banks of one row per output column, one counter lane per label
	localparam int ROWS = 2 * MAX_OUT_WIDTH;
	localparam int ROW_W = COL_W + 1;

	localparam int GROUP = 4;
	localparam int NUM_GROUPS = NUM_LABELS / GROUP;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(4096);
	localparam logic [OW_W-1:0] OUT_MAX = OW_W'(MAX_OUT_WIDTH);

	localparam logic [DIM_W-1:0] IN_WIDTH_RST = DIM_W'(820);
	localparam logic [DIM_W-1:0] IN_HEIGHT_RST = DIM_W'(616);
	localparam logic [OW_W-1:0] OUT_WIDTH_RST = OW_W'(64);
	localparam logic [OW_W-1:0] OUT_HEIGHT_RST = OW_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_WIDTH   = 3'd0,
		CFG_IN_HEIGHT  = 3'd1,
		CFG_OUT_WIDTH  = 3'd2,
		CFG_OUT_HEIGHT = 3'd3
	} cfg_idx_t;

	typedef enum logic {
		SCAN_IDLE,
		SCAN_RUN
	} scan_state_t;

	typedef struct packed {
		logic [COL_W-1:0]   col;
		logic [LABEL_W-1:0] label;
		logic               band_end;
		logic               frame_end;
	} pix_entry_t;

	typedef struct packed {
		logic            restart;
		logic [OW_W-1:0] ow;
	} ctrl_t;

	typedef logic [NUM_LABELS-1:0][CNT_W-1:0] cnt_row_t;

endpackage

// ===== rtl/core/lmd_front.sv =====
// front end: config registers, raster position tracking and pixel classification
module lmd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	output logic                           pixel_stall,
	input  logic [lmd_pkg::LABEL_W-1:0]    pixel_label,
	input  logic                           cfg_we,
	input  logic [lmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lmd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           fifo_full,
	output logic                           push,
	output lmd_pkg::pix_entry_t            push_data,
	output lmd_pkg::ctrl_t                 ctrl
);

	logic [lmd_pkg::DIM_W-1:0] in_width_q, in_height_q;
	logic [lmd_pkg::OW_W-1:0]  out_width_q, out_height_q;

	logic [lmd_pkg::DIM_W-1:0] iw, ih;
	logic [lmd_pkg::OW_W-1:0]  ow_c, oh_c, ow, oh;

	logic [lmd_pkg::POS_W-1:0] x_q, y_q, rem_x_q, rem_y_q;
	logic [lmd_pkg::COL_W-1:0] ox_q;

	logic                      cfg_hit, restart, accept;
	logic [lmd_pkg::DIM_W-1:0] x_inc, y_inc, rx_sum, ry_sum;
	logic [lmd_pkg::POS_W-1:0] rx_next, ry_next;
	logic                      row_end, frame_end, rx_wrap, ry_wrap, band_end;

	always_comb begin
		case (lmd_pkg::cfg_idx_t'(cfg_index))
			lmd_pkg::CFG_IN_WIDTH:   cfg_hit = 1'b1;
			lmd_pkg::CFG_IN_HEIGHT:  cfg_hit = 1'b1;
			lmd_pkg::CFG_OUT_WIDTH:  cfg_hit = 1'b1;
			lmd_pkg::CFG_OUT_HEIGHT: cfg_hit = 1'b1;
			default:                 cfg_hit = 1'b0;
		endcase
	end

	assign restart = cfg_we && cfg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= lmd_pkg::IN_WIDTH_RST;
			in_height_q  <= lmd_pkg::IN_HEIGHT_RST;
			out_width_q  <= lmd_pkg::OUT_WIDTH_RST;
			out_height_q <= lmd_pkg::OUT_HEIGHT_RST;
		end else if (cfg_we) begin
			case (lmd_pkg::cfg_idx_t'(cfg_index))
				lmd_pkg::CFG_IN_WIDTH:   in_width_q <= cfg_data;
				lmd_pkg::CFG_IN_HEIGHT:  in_height_q <= cfg_data;
				lmd_pkg::CFG_OUT_WIDTH:  out_width_q <= cfg_data[lmd_pkg::OW_W-1:0];
				lmd_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg_data[lmd_pkg::OW_W-1:0];
				default: ;
			endcase
		end
	end

	// effective dimensions
	always_comb begin
		if (in_width_q == '0) iw = lmd_pkg::DIM_W'(1);
		else if (in_width_q > lmd_pkg::DIM_MAX) iw = lmd_pkg::DIM_MAX;
		else iw = in_width_q;

		if (in_height_q == '0) ih = lmd_pkg::DIM_W'(1);
		else if (in_height_q > lmd_pkg::DIM_MAX) ih = lmd_pkg::DIM_MAX;
		else ih = in_height_q;

		if (out_width_q == '0) ow_c = lmd_pkg::OW_W'(1);
		else if (out_width_q > lmd_pkg::OUT_MAX) ow_c = lmd_pkg::OUT_MAX;
		else ow_c = out_width_q;
		ow = (lmd_pkg::DIM_W'(ow_c) > iw) ? lmd_pkg::OW_W'(iw) : ow_c;

		if (out_height_q == '0) oh_c = lmd_pkg::OW_W'(1);
		else oh_c = out_height_q;
		oh = (lmd_pkg::DIM_W'(oh_c) > ih) ? lmd_pkg::OW_W'(ih) : oh_c;
	end

	// cell index kept as quotient plus remainder, stepped by compare and subtract
	always_comb begin
		x_inc     = lmd_pkg::DIM_W'(x_q) + lmd_pkg::DIM_W'(1);
		y_inc     = lmd_pkg::DIM_W'(y_q) + lmd_pkg::DIM_W'(1);
		row_end   = x_inc >= iw;
		frame_end = y_inc >= ih;
		rx_sum    = lmd_pkg::DIM_W'(rem_x_q) + lmd_pkg::DIM_W'(ow);
		ry_sum    = lmd_pkg::DIM_W'(rem_y_q) + lmd_pkg::DIM_W'(oh);
		rx_wrap   = rx_sum >= iw;
		ry_wrap   = ry_sum >= ih;
		rx_next   = rx_wrap ? lmd_pkg::POS_W'(rx_sum - iw) : lmd_pkg::POS_W'(rx_sum);
		ry_next   = ry_wrap ? lmd_pkg::POS_W'(ry_sum - ih) : lmd_pkg::POS_W'(ry_sum);
		band_end  = frame_end || ry_wrap;
	end

	assign accept      = pixel_valid && !fifo_full;
	assign pixel_stall = fifo_full;
	assign push        = accept;

	assign push_data.col       = ox_q;
	assign push_data.label     = pixel_label;
	assign push_data.band_end  = row_end && band_end;
	assign push_data.frame_end = row_end && frame_end;

	assign ctrl.restart = restart;
	assign ctrl.ow      = ow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			rem_x_q <= '0;
			rem_y_q <= '0;
			ox_q    <= '0;
		end else if (restart) begin
			x_q     <= '0;
			y_q     <= '0;
			rem_x_q <= '0;
			rem_y_q <= '0;
			ox_q    <= '0;
		end else if (accept) begin
			if (row_end) begin
				x_q     <= '0;
				rem_x_q <= '0;
				ox_q    <= '0;
				if (frame_end) begin
					y_q     <= '0;
					rem_y_q <= '0;
				end else begin
					y_q     <= y_inc[lmd_pkg::POS_W-1:0];
					rem_y_q <= ry_next;
				end
			end else begin
				x_q     <= x_inc[lmd_pkg::POS_W-1:0];
				rem_x_q <= rx_next;
				if (rx_wrap) ox_q <= ox_q + lmd_pkg::COL_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/lmd_fifo.sv =====
// short queue of classified pixels between front end and counter back end
module lmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lmd_pkg::pix_entry_t push_data,
	input  logic                pop,
	output lmd_pkg::pix_entry_t head,
	output logic                empty,
	output logic                full
);

	lmd_pkg::pix_entry_t            entry_q [lmd_pkg::FIFO_DEPTH];
	logic [lmd_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [lmd_pkg::FIFO_CNT_W-1:0] count_q;

	assign empty = count_q == '0;
	assign full  = count_q == lmd_pkg::FIFO_CNT_W'(lmd_pkg::FIFO_DEPTH);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + lmd_pkg::FIFO_PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + lmd_pkg::FIFO_PTR_W'(1);
			if (push && !pop) count_q <= count_q + lmd_pkg::FIFO_CNT_W'(1);
			else if (pop && !push) count_q <= count_q - lmd_pkg::FIFO_CNT_W'(1);
		end
	end

endmodule

// ===== rtl/core/lmd_back.sv =====
// back end: double-banked label counters, band scan with argmax and result register
module lmd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lmd_pkg::ctrl_t               ctrl,
	input  logic                         fifo_empty,
	input  lmd_pkg::pix_entry_t          fifo_head,
	output logic                         pop,
	output logic                         cell_valid,
	input  logic                         cell_stall,
	output logic [lmd_pkg::LABEL_W-1:0]  cell_label,
	output logic [lmd_pkg::CELL_COL_W-1:0] cell_column,
	output logic                         row_last,
	output logic                         frame_last
);

	typedef struct packed {
		logic [lmd_pkg::CNT_W-1:0]   cnt;
		logic [lmd_pkg::LABEL_W-1:0] label;
	} cand_t;

	function automatic cand_t pick(cand_t a, cand_t b);
		// strict compare keeps the lower label on a tie
		pick = (b.cnt > a.cnt) ? b : a;
	endfunction

	lmd_pkg::cnt_row_t cnt_mem [lmd_pkg::ROWS];

	logic                         bank_q, scan_bank_q;
	logic [1:0]                   bank_busy_q, scan_req_q, frame_q;
	logic [lmd_pkg::ROWS-1:0]     row_valid_q;

	// pixel update stage
	logic                         pix_vld_s1, band_s1;
	logic [lmd_pkg::ROW_W-1:0]    row_s1, pop_row;
	logic [lmd_pkg::LABEL_W-1:0]  lbl_s1;
	lmd_pkg::cnt_row_t            rd_a_s1, base_row, new_row;
	logic                         wr_vld_q;
	logic [lmd_pkg::ROW_W-1:0]    wr_row_q;
	lmd_pkg::cnt_row_t            wr_data_q;

	// scan
	lmd_pkg::scan_state_t         state_q, state_d;
	logic [lmd_pkg::COL_W-1:0]    scol_q;
	logic [lmd_pkg::ROW_W-1:0]    scan_row;
	logic                         adv, issue, last_col;
	logic                         sc_vld_s1, sc_ok_s1, sc_rlast_s1, sc_flast_s1;
	logic [lmd_pkg::COL_W-1:0]    sc_col_s1;
	lmd_pkg::cnt_row_t            rd_b_s1;
	cand_t                        cand [lmd_pkg::NUM_LABELS];
	cand_t                        grp_d [lmd_pkg::NUM_GROUPS];
	cand_t                        grp_s2 [lmd_pkg::NUM_GROUPS];
	cand_t                        fin;
	logic                         sc_vld_s2, rlast_s2, flast_s2;
	logic [lmd_pkg::COL_W-1:0]    col_s2;
	logic                         out_vld_q, out_rlast_q, out_flast_q;
	logic [lmd_pkg::LABEL_W-1:0]  out_label_q;
	logic [lmd_pkg::COL_W-1:0]    out_col_q;

	// a new band waits until the scan has drained the bank it is about to fill
	assign pop     = !fifo_empty && !bank_busy_q[bank_q];
	assign pop_row = {bank_q, fifo_head.col};

	assign adv      = !out_vld_q || !cell_stall;
	assign issue    = (state_q == lmd_pkg::SCAN_RUN) && adv;
	assign scan_row = {scan_bank_q, scol_q};
	assign last_col = lmd_pkg::OW_W'(scol_q) == (ctrl.ow - lmd_pkg::OW_W'(1));

	always_ff @(posedge clk) begin
		if (pix_vld_s1) cnt_mem[row_s1] <= new_row;
		if (pop) rd_a_s1 <= cnt_mem[pop_row];
		if (issue) rd_b_s1 <= cnt_mem[scan_row];
	end

	// read-modify-write; the row written on the edge of this read comes from the bypass
	always_comb begin
		if (wr_vld_q && wr_row_q == row_s1) base_row = wr_data_q;
		else if (row_valid_q[row_s1]) base_row = rd_a_s1;
		else base_row = '0;
		new_row = base_row;
		if (lbl_s1 != '0 && 32'(lbl_s1) < lmd_pkg::NUM_LABELS
				&& base_row[lbl_s1] != lmd_pkg::CNT_MAX) begin
			new_row[lbl_s1] = base_row[lbl_s1] + lmd_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			row_s1 <= pop_row;
			lbl_s1 <= fifo_head.label;
		end
		if (pix_vld_s1) begin
			wr_row_q  <= row_s1;
			wr_data_q <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= 1'b0;
			scan_bank_q <= 1'b0;
			bank_busy_q <= '0;
			scan_req_q  <= '0;
			frame_q     <= '0;
			row_valid_q <= '0;
			pix_vld_s1  <= 1'b0;
			band_s1     <= 1'b0;
			wr_vld_q    <= 1'b0;
			scol_q      <= '0;
		end else if (ctrl.restart) begin
			bank_q      <= 1'b0;
			scan_bank_q <= 1'b0;
			bank_busy_q <= '0;
			scan_req_q  <= '0;
			frame_q     <= '0;
			row_valid_q <= '0;
			pix_vld_s1  <= 1'b0;
			band_s1     <= 1'b0;
			wr_vld_q    <= 1'b0;
			scol_q      <= '0;
		end else begin
			pix_vld_s1 <= pop;
			band_s1    <= pop && fifo_head.band_end;
			wr_vld_q   <= pix_vld_s1;
			if (pop && fifo_head.band_end) begin
				bank_busy_q[bank_q] <= 1'b1;
				frame_q[bank_q]     <= fifo_head.frame_end;
				bank_q              <= ~bank_q;
			end
			if (pix_vld_s1) begin
				row_valid_q[row_s1] <= 1'b1;
				if (band_s1) scan_req_q[row_s1[lmd_pkg::ROW_W-1]] <= 1'b1;
			end
			// scanned rows read as empty from then on
			if (issue) begin
				row_valid_q[scan_row] <= 1'b0;
				if (last_col) begin
					scol_q                   <= '0;
					bank_busy_q[scan_bank_q] <= 1'b0;
					scan_req_q[scan_bank_q]  <= 1'b0;
					scan_bank_q              <= ~scan_bank_q;
				end else begin
					scol_q <= scol_q + lmd_pkg::COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmd_pkg::SCAN_IDLE;
		end else if (ctrl.restart) begin
			state_q <= lmd_pkg::SCAN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lmd_pkg::SCAN_IDLE: begin
				if (scan_req_q[scan_bank_q]) state_d = lmd_pkg::SCAN_RUN;
			end
			lmd_pkg::SCAN_RUN: begin
				if (issue && last_col) state_d = lmd_pkg::SCAN_IDLE;
			end
			default: state_d = lmd_pkg::SCAN_IDLE;
		endcase
	end

	// argmax in two registered levels: within groups, then across groups
	always_comb begin
		for (int l = 0; l < lmd_pkg::NUM_LABELS; l++) begin
			cand[l].label = lmd_pkg::LABEL_W'(l);
			cand[l].cnt   = (l == 0 || !sc_ok_s1) ? '0 : rd_b_s1[l];
		end
		for (int g = 0; g < lmd_pkg::NUM_GROUPS; g++) begin
			grp_d[g] = cand[g * lmd_pkg::GROUP];
			for (int j = 1; j < lmd_pkg::GROUP; j++) begin
				grp_d[g] = pick(grp_d[g], cand[g * lmd_pkg::GROUP + j]);
			end
		end
		fin = grp_s2[0];
		for (int g = 1; g < lmd_pkg::NUM_GROUPS; g++) begin
			fin = pick(fin, grp_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_vld_s1 <= 1'b0;
			sc_vld_s2 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			sc_vld_s1 <= issue;
			sc_vld_s2 <= sc_vld_s1;
			out_vld_q <= sc_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sc_ok_s1    <= row_valid_q[scan_row];
			sc_col_s1   <= scol_q;
			sc_rlast_s1 <= last_col;
			sc_flast_s1 <= last_col && frame_q[scan_bank_q];
		end
		if (adv) begin
			grp_s2      <= grp_d;
			col_s2      <= sc_col_s1;
			rlast_s2    <= sc_rlast_s1;
			flast_s2    <= sc_flast_s1;
			out_label_q <= fin.label;
			out_col_q   <= col_s2;
			out_rlast_q <= rlast_s2;
			out_flast_q <= flast_s2;
		end
	end

	assign cell_valid  = out_vld_q;
	assign cell_label  = out_label_q;
	assign cell_column = out_col_q[lmd_pkg::CELL_COL_W-1:0];
	assign row_last    = out_rlast_q;
	assign frame_last  = out_flast_q;

endmodule

// ===== rtl/core/label_mode_downsample_top.sv =====
// a band's cells come out of its scan through the row read, group and output registers
// throughput: one pixel per cycle unless pixel_stall; one cell per cycle while the band
// scan runs and cell_stall is low; a band scan covers the effective output width and
// holds its bank of the double-banked counter store; pixels of the band after next wait in
// the four-entry queue until that bank drains, and the input stalls once the queue fills
// reset and config register writes clear position and counters at once (valid bit per row)
module label_mode_downsample_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	output logic                           pixel_stall,
	input  logic [lmd_pkg::LABEL_W-1:0]    pixel_label,
	output logic                           cell_valid,
	input  logic                           cell_stall,
	output logic [lmd_pkg::LABEL_W-1:0]    cell_label,
	output logic [lmd_pkg::CELL_COL_W-1:0] cell_column,
	output logic                           row_last,
	output logic                           frame_last,
	input  logic                           cfg_we,
	input  logic [lmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lmd_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                fifo_push, fifo_pop, fifo_empty, fifo_full;
	lmd_pkg::pix_entry_t fifo_in, fifo_head;
	lmd_pkg::ctrl_t      ctrl;

	lmd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_label (pixel_label),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fifo_full   (fifo_full),
		.push        (fifo_push),
		.push_data   (fifo_in),
		.ctrl        (ctrl)
	);

	lmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (fifo_in),
		.pop       (fifo_pop),
		.head      (fifo_head),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	lmd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.fifo_empty  (fifo_empty),
		.fifo_head   (fifo_head),
		.pop         (fifo_pop),
		.cell_valid  (cell_valid),
		.cell_stall  (cell_stall),
		.cell_label  (cell_label),
		.cell_column (cell_column),
		.row_last    (row_last),
		.frame_last  (frame_last)
	);

`ifndef SYNTHESIS
	a_frame_last_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && frame_last |-> row_last)
		else $error("frame_last without row_last");

	a_row_end_column: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && row_last |->
			cell_column == lmd_pkg::CELL_COL_W'(ctrl.ow - lmd_pkg::OW_W'(1)))
		else $error("row_last on a column other than the last");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> !fifo_empty)
		else $error("queue popped while empty");
`endif

endmodule

// ===== test/tb.sv =====
// testbench for the label mode downsampler: predicts each output cell and checks it
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 20;
	localparam int DIM_LIMIT = 4096;
	localparam logic [lmd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
	localparam logic [lmd_pkg::CFG_IDX_W-1:0] CFG_LAST_IDX = 3'd7;

	typedef struct {
		logic [lmd_pkg::LABEL_W-1:0]    label;
		logic [lmd_pkg::CELL_COL_W-1:0] column;
		logic                           row_last;
		logic                           frame_last;
	} cell_t;

	class mode_scoreboard;
		logic [lmd_pkg::DIM_W-1:0] in_width_q;
		logic [lmd_pkg::DIM_W-1:0] in_height_q;
		logic [lmd_pkg::OW_W-1:0]  out_width_q;
		logic [lmd_pkg::OW_W-1:0]  out_height_q;
		logic [lmd_pkg::CNT_W-1:0] tally [lmd_pkg::MAX_OUT_WIDTH][lmd_pkg::NUM_LABELS];
		int unsigned col_pos;
		int unsigned row_pos;
		cell_t cells_due[$];
		int mismatches;

		function new();
			in_width_q = lmd_pkg::IN_WIDTH_RST;
			in_height_q = lmd_pkg::IN_HEIGHT_RST;
			out_width_q = lmd_pkg::OUT_WIDTH_RST;
			out_height_q = lmd_pkg::OUT_HEIGHT_RST;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			foreach (tally[c, l])
				tally[c][l] = '0;
			col_pos = 0;
			row_pos = 0;
		endfunction

		function int unsigned limit(int unsigned v, int unsigned lo, int unsigned hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void write_reg(input logic [lmd_pkg::CFG_IDX_W-1:0] idx,
				input logic [lmd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				lmd_pkg::CFG_IN_WIDTH: in_width_q = data;
				lmd_pkg::CFG_IN_HEIGHT: in_height_q = data;
				lmd_pkg::CFG_OUT_WIDTH: out_width_q = data[lmd_pkg::OW_W-1:0];
				lmd_pkg::CFG_OUT_HEIGHT: out_height_q = data[lmd_pkg::OW_W-1:0];
				default: return;
			endcase
			restart();
		endfunction

		function void note_pixel(input logic [lmd_pkg::LABEL_W-1:0] lab);
			int unsigned iw, ih, ow, oh, x, y, ox, oy, best, win;
			bit frame_done, band_done;
			cell_t c;
			iw = limit(in_width_q, 1, DIM_LIMIT);
			ih = limit(in_height_q, 1, DIM_LIMIT);
			ow = limit(out_width_q, 1, lmd_pkg::MAX_OUT_WIDTH);
			oh = limit(out_height_q, 1, ih);
			if (ow > iw)
				ow = iw;
			x = (col_pos < iw) ? col_pos : 0;
			y = (row_pos < ih) ? row_pos : 0;
			ox = x * ow / iw;
			oy = y * oh / ih;
			if (lab != 0 && tally[ox][lab] != lmd_pkg::CNT_MAX)
				tally[ox][lab]++;
			frame_done = (y + 1 >= ih);
			band_done = frame_done || ((y + 1) * oh / ih != oy);
			if (x + 1 >= iw && band_done) begin
				for (int k = 0; k < ow; k++) begin
					best = 0;
					win = 0;
					// strict compare keeps the lowest label on a tie
					for (int l = 1; l < lmd_pkg::NUM_LABELS; l++) begin
						if (tally[k][l] > best) begin
							best = tally[k][l];
							win = l;
						end
					end
					c.label = lmd_pkg::LABEL_W'(win);
					c.column = lmd_pkg::CELL_COL_W'(k);
					c.row_last = (k + 1 == ow);
					c.frame_last = (k + 1 == ow) && frame_done;
					cells_due = {cells_due, c};
				end
				foreach (tally[cc, l])
					tally[cc][l] = '0;
			end
			x++;
			if (x >= iw) begin
				x = 0;
				y++;
				if (y >= ih)
					y = 0;
			end
			col_pos = x;
			row_pos = y;
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_cell(input cell_t got);
			cell_t want;
			if (cells_due.size() == 0) begin
				report($sformatf("unexpected cell column %0d label %0d", got.column, got.label));
				return;
			end
			want = cells_due.pop_front();
			if (got.label !== want.label)
				report($sformatf("column %0d label %0d, want %0d", want.column, got.label,
					want.label));
			if (got.column !== want.column)
				report($sformatf("cell_column %0d, want %0d", got.column, want.column));
			if (got.row_last !== want.row_last)
				report($sformatf("column %0d row_last %0b, want %0b", want.column, got.row_last,
					want.row_last));
			if (got.frame_last !== want.frame_last)
				report($sformatf("column %0d frame_last %0b, want %0b", want.column,
					got.frame_last, want.frame_last));
		endtask
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           pixel_valid;
	logic                           pixel_stall;
	logic [lmd_pkg::LABEL_W-1:0]    pixel_label;
	logic                           cell_valid;
	logic                           cell_stall = 1'b0;
	logic [lmd_pkg::LABEL_W-1:0]    cell_label;
	logic [lmd_pkg::CELL_COL_W-1:0] cell_column;
	logic                           row_last;
	logic                           frame_last;
	logic                           cfg_we;
	logic [lmd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lmd_pkg::CFG_DATA_W-1:0] cfg_data;

	mode_scoreboard sb = new();
	int send_gap_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	label_mode_downsample_top uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk)
		cell_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin : cell_monitor
		cell_t seen;
		if (arst_n && cell_valid && !cell_stall) begin
			seen.label = cell_label;
			seen.column = cell_column;
			seen.row_last = row_last;
			seen.frame_last = frame_last;
			sb.check_cell(seen);
		end
	end

	// entered and left on a falling edge
	task automatic send_pixel(input logic [lmd_pkg::LABEL_W-1:0] lab);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_label <= lab;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		sb.note_pixel(lab);
		@(negedge clk);
	endtask

	// lets every pending cell out, then waits out the settle time for beats that make no cell
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (sb.cells_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [lmd_pkg::CFG_IDX_W-1:0] idx,
			input logic [lmd_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_dims(input int unsigned iw, input int unsigned ih, input int unsigned ow,
			input int unsigned oh);
		wait_idle();
		cfg_write(lmd_pkg::CFG_IN_WIDTH, lmd_pkg::CFG_DATA_W'(iw));
		cfg_write(lmd_pkg::CFG_IN_HEIGHT, lmd_pkg::CFG_DATA_W'(ih));
		cfg_write(lmd_pkg::CFG_OUT_WIDTH, lmd_pkg::CFG_DATA_W'(ow));
		cfg_write(lmd_pkg::CFG_OUT_HEIGHT, lmd_pkg::CFG_DATA_W'(oh));
	endtask

	task automatic random_phase(input bit wide);
		int unsigned iw, ih, ow, oh, beats, r;
		logic [lmd_pkg::LABEL_W-1:0] fav, lab;
		if (wide) begin
			// full-width output row: each cell covers one or two pixels
			iw = $urandom_range(lmd_pkg::MAX_OUT_WIDTH, lmd_pkg::MAX_OUT_WIDTH + 2);
			ih = 1;
			ow = $urandom_range(0, 1) ? lmd_pkg::MAX_OUT_WIDTH : 127;
			oh = 1;
			beats = iw;
		end else begin
			iw = $urandom_range(1, 12);
			ih = $urandom_range(1, 6);
			ow = $urandom_range(1, iw + 1);
			oh = $urandom_range(0, ih + 1);
			beats = $urandom_range(4, 12);
		end
		set_dims(iw, ih, ow, oh);
		if ($urandom_range(0, 3) == 0)
			cfg_write(lmd_pkg::CFG_IDX_W'($urandom_range(lmd_pkg::CFG_OUT_HEIGHT + 1,
				CFG_LAST_IDX)), lmd_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
		fav = lmd_pkg::LABEL_W'($urandom_range(1, lmd_pkg::NUM_LABELS - 1));
		repeat (beats) begin
			r = $urandom_range(0, 9);
			// a favorite and its neighbor make majorities and ties
			if (r < 4)
				lab = fav;
			else if (r == 4)
				lab = '0;
			else if (r < 7)
				lab = lmd_pkg::LABEL_W'(fav % (lmd_pkg::NUM_LABELS - 1) + 1);
			else
				lab = lmd_pkg::LABEL_W'($urandom_range(0, lmd_pkg::NUM_LABELS - 1));
			send_pixel(lab);
		end
	endtask

	initial begin
		pixel_valid = 1'b0;
		pixel_label = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_gap_pct = 28;
		stall_pct = 79;

		// reset dimensions: a few pixels that never finish a band
		send_pixel(4'd15);
		send_pixel(4'd0);
		send_pixel(4'd6);

		// two cells: a tie between 5 and 7, and a lone 15
		set_dims(4, 2, 2, 1);
		send_pixel(4'd5);
		send_pixel(4'd7);
		send_pixel(4'd0);
		send_pixel(4'd0);
		send_pixel(4'd7);
		send_pixel(4'd5);
		send_pixel(4'd15);
		send_pixel(4'd0);

		// output wider than input, zero output height, write to an unused index mid frame
		set_dims(3, 2, 127, 0);
		send_pixel(4'd1);
		send_pixel(4'd0);
		wait_idle();
		cfg_write(CFG_UNUSED, 13'h1fff);
		send_pixel(4'd2);
		send_pixel(4'd0);
		send_pixel(4'd0);
		send_pixel(4'd1);

		// zero dimensions clamp to one: every pixel ends a frame
		set_dims(0, 0, 0, 1);
		send_pixel(4'd15);
		send_pixel(4'd0);
		send_pixel(4'd8);

		// largest dimensions
		set_dims(8191, 4096, lmd_pkg::MAX_OUT_WIDTH, lmd_pkg::MAX_OUT_WIDTH);
		send_pixel(4'd10);
		send_pixel(4'd3);
		send_pixel(4'd0);
		send_pixel(4'd12);

		for (int mode = 0; mode < 3; mode++) begin
			if (mode == 1) begin
				send_gap_pct = 79;
				stall_pct = 28;
			end else if (mode == 2) begin
				send_gap_pct = 0;
				stall_pct = 0;
			end
			for (int p = 0; p < 4; p++)
				random_phase(mode == 0 && p == 3);
		end

		wait_idle();
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== label_mode_downsample_top.f =====
rtl/core/lmd_pkg.sv
rtl/core/lmd_front.sv
rtl/core/lmd_fifo.sv
rtl/core/lmd_back.sv
rtl/core/label_mode_downsample_top.sv
test/tb.sv
